>>> hw/rtl/rkx_pkg.sv
// Shared types, register codes and character constants for the XOR hex grouper.
package rkx_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int KEY_WIDTH   = 64;
   localparam int LEN_WIDTH   = 4;
   localparam int CPG_WIDTH   = 6;
   localparam int GPL_WIDTH   = 8;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY_BYTES       = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY_LENGTH      = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHARS_PER_GROUP = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GROUPS_PER_LINE = 2'd3;

   localparam logic [LEN_WIDTH-1:0] KEY_LENGTH_RESET      = 4'd8;
   localparam logic [LEN_WIDTH-1:0] KEY_LENGTH_MAX        = 4'd8;
   localparam logic [CPG_WIDTH-1:0] CHARS_PER_GROUP_RESET = 6'd6;
   localparam logic [GPL_WIDTH-1:0] GROUPS_PER_LINE_RESET = 8'd10;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key_bytes;
      logic [LEN_WIDTH-1:0] key_length;
      logic [CPG_WIDTH-1:0] chars_per_group;
      logic [GPL_WIDTH-1:0] groups_per_line;
   } cfg_type;

   typedef enum logic [1:0] {
      PHASE_HI,
      PHASE_SEP_HI,
      PHASE_LO,
      PHASE_SEP_LO
   } phase_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] result;
      if (nibble < 4'd10) begin
         result = CHAR_ZERO + {4'd0, nibble};
      end else begin
         result = CHAR_UPPER_A + {4'd0, nibble} - 8'd10;
      end
      return result;
   endfunction

endpackage

>>> hw/rtl/rkx_queue.sv
// Small FIFO that decouples the cipher front end from the character back end.
module rkx_queue #(
   parameter int Depth = rkx_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  logic [7:0] push_data,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output logic [7:0] head_data
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   logic [7:0]            mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == CountWidth'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/rkx_front.sv
// Front end: accepts plaintext beats and XORs them with the repeating key.
module rkx_front (
   input  logic             clock,
   input  logic             reset,
   input  rkx_pkg::cfg_type cfg,
   input  logic             req_valid,
   input  logic [7:0]       req_plain_byte,
   output logic             req_stall,
   input  logic             queue_full,
   output logic             push_valid,
   output logic [7:0]       push_data
);

   logic [2:0]                    key_position_ff, key_position_in;
   logic [rkx_pkg::LEN_WIDTH-1:0] eff_len;
   logic [2:0]                    cur_pos;
   logic [rkx_pkg::LEN_WIDTH-1:0] next_pos;
   logic [7:0]                    key_byte;
   logic                          accept;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;
   assign push_data  = req_plain_byte ^ key_byte;

   always_comb begin
      // A length of zero acts as one, anything above eight as eight.
      if (cfg.key_length == '0) begin
         eff_len = rkx_pkg::LEN_WIDTH'(1);
      end else if (cfg.key_length > rkx_pkg::KEY_LENGTH_MAX) begin
         eff_len = rkx_pkg::KEY_LENGTH_MAX;
      end else begin
         eff_len = cfg.key_length;
      end

      // A position left beyond a shortened key falls back to byte zero.
      cur_pos  = ({1'b0, key_position_ff} >= eff_len) ? 3'd0 : key_position_ff;
      key_byte = cfg.key_bytes[{cur_pos, 3'b000} +: 8];

      next_pos = {1'b0, cur_pos} + 1'b1;
      if (next_pos >= eff_len) begin
         next_pos = '0;
      end

      key_position_in = accept ? next_pos[2:0] : key_position_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_position_ff <= '0;
      end else begin
         key_position_ff <= key_position_in;
      end
   end

endmodule

>>> hw/rtl/rkx_back.sv
// Back end: turns each cipher byte into hex characters and group separators.
module rkx_back (
   input  logic             clock,
   input  logic             reset,
   input  rkx_pkg::cfg_type cfg,
   input  logic             head_valid,
   input  logic [7:0]       head_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last_of_run,
   output logic             rsp_line_open
);

   rkx_pkg::phase_type phase_ff, phase_in;
   logic [rkx_pkg::CPG_WIDTH-1:0] char_count_ff, char_count_in;
   logic [rkx_pkg::GPL_WIDTH-1:0] group_count_ff, group_count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_out_char_ff, rsp_out_char_in;
   logic                          rsp_last_of_run_ff, rsp_last_of_run_in;
   logic                          rsp_line_open_ff, rsp_line_open_in;
   logic                          out_free, step;
   logic [rkx_pkg::CPG_WIDTH:0]   cc_next;
   logic [rkx_pkg::GPL_WIDTH:0]   gc_next;
   logic                          group_done, line_done;
   logic [3:0]                    nibble;

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign step            = out_free && head_valid;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_out_char_ff;
   assign rsp_last_of_run = rsp_last_of_run_ff;
   assign rsp_line_open   = rsp_line_open_ff;

   always_comb begin
      cc_next    = {1'b0, char_count_ff} + 1'b1;
      gc_next    = {1'b0, group_count_ff} + 1'b1;
      group_done = (cc_next >= {1'b0, cfg.chars_per_group});
      line_done  = (gc_next >= {1'b0, cfg.groups_per_line});
      nibble     = (phase_ff == rkx_pkg::PHASE_HI) ? head_data[7:4] : head_data[3:0];

      phase_in           = phase_ff;
      char_count_in      = char_count_ff;
      group_count_in     = group_count_ff;
      rsp_out_char_in    = rsp_out_char_ff;
      rsp_last_of_run_in = rsp_last_of_run_ff;
      rsp_line_open_in   = rsp_line_open_ff;
      rsp_valid_in       = out_free ? 1'b0 : rsp_valid_ff;
      pop                = 1'b0;

      if (step) begin
         rsp_valid_in = 1'b1;
         case (phase_ff)
            rkx_pkg::PHASE_HI, rkx_pkg::PHASE_LO: begin
               rsp_out_char_in  = rkx_pkg::hex_char(nibble);
               rsp_line_open_in = (group_count_ff != '0);
               if (group_done) begin
                  char_count_in      = '0;
                  rsp_last_of_run_in = 1'b0;
                  phase_in = (phase_ff == rkx_pkg::PHASE_HI) ? rkx_pkg::PHASE_SEP_HI
                                                             : rkx_pkg::PHASE_SEP_LO;
               end else begin
                  char_count_in = cc_next[rkx_pkg::CPG_WIDTH-1:0];
                  if (phase_ff == rkx_pkg::PHASE_HI) begin
                     rsp_last_of_run_in = 1'b0;
                     phase_in           = rkx_pkg::PHASE_LO;
                  end else begin
                     rsp_last_of_run_in = 1'b1;
                     pop                = 1'b1;
                     phase_in           = rkx_pkg::PHASE_HI;
                  end
               end
            end
            rkx_pkg::PHASE_SEP_HI, rkx_pkg::PHASE_SEP_LO: begin
               if (line_done) begin
                  group_count_in   = '0;
                  rsp_out_char_in  = rkx_pkg::CHAR_NEWLINE;
                  rsp_line_open_in = 1'b0;
               end else begin
                  group_count_in   = gc_next[rkx_pkg::GPL_WIDTH-1:0];
                  rsp_out_char_in  = rkx_pkg::CHAR_SPACE;
                  rsp_line_open_in = (gc_next[rkx_pkg::GPL_WIDTH-1:0] != '0);
               end
               if (phase_ff == rkx_pkg::PHASE_SEP_HI) begin
                  rsp_last_of_run_in = 1'b0;
                  phase_in           = rkx_pkg::PHASE_LO;
               end else begin
                  rsp_last_of_run_in = 1'b1;
                  pop                = 1'b1;
                  phase_in           = rkx_pkg::PHASE_HI;
               end
            end
            default: begin
               phase_in = rkx_pkg::PHASE_HI;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= rkx_pkg::PHASE_HI;
         char_count_ff  <= '0;
         group_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         char_count_ff  <= char_count_in;
         group_count_ff <= group_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_char_ff    <= rsp_out_char_in;
      rsp_last_of_run_ff <= rsp_last_of_run_in;
      rsp_line_open_ff   <= rsp_line_open_in;
   end

endmodule

>>> hw/rtl/repeating_key_xor_hex_grouper_unit.sv
// Top level of the repeating-key XOR encryptor with grouped hex output.
//
// Usage: the req channel takes one plaintext byte per beat; the rsp channel
// gives one ASCII character per beat: two uppercase hex digits per byte, high
// nibble first, each followed by a space or newline when it closes a group.
// rsp_last_of_run marks the final character of a byte; rsp_line_open is high
// while the current line holds completed groups, so the host can pad.
// The csr port writes the key, key length, group size and groups per line;
// write it only while no bytes are in flight.
// Data path: an accepted byte is written into the queue, and the back end then
// registers each of its characters in its single character output register.
// Throughput: one character per cycle while rsp_stall is low, so a byte takes
// two to four characters, all passing through that one output register.
// A four-entry queue lets the input keep taking bytes while output drains.
// Reset clears the key position, counters, queue and output valid, and
// restores the register defaults. While rsp_stall is high the output holds
// and, once the queue fills, req_stall rises.
module repeating_key_xor_hex_grouper_unit #(
   parameter int QueueDepth = rkx_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rkx_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [rkx_pkg::KEY_WIDTH-1:0]       csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_plain_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_char,
   output logic                                rsp_last_of_run,
   output logic                                rsp_line_open
);

   rkx_pkg::cfg_type cfg_ff, cfg_in;
   logic             queue_full, push_valid, pop, head_valid;
   logic [7:0]       push_data, head_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rkx_pkg::CSR_KEY_BYTES:       cfg_in.key_bytes = csr_write_data;
            rkx_pkg::CSR_KEY_LENGTH:
               cfg_in.key_length = csr_write_data[rkx_pkg::LEN_WIDTH-1:0];
            rkx_pkg::CSR_CHARS_PER_GROUP:
               cfg_in.chars_per_group = csr_write_data[rkx_pkg::CPG_WIDTH-1:0];
            rkx_pkg::CSR_GROUPS_PER_LINE:
               cfg_in.groups_per_line = csr_write_data[rkx_pkg::GPL_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_bytes       <= '0;
         cfg_ff.key_length      <= rkx_pkg::KEY_LENGTH_RESET;
         cfg_ff.chars_per_group <= rkx_pkg::CHARS_PER_GROUP_RESET;
         cfg_ff.groups_per_line <= rkx_pkg::GROUPS_PER_LINE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rkx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_plain_byte (req_plain_byte),
      .req_stall      (req_stall),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_data      (push_data)
   );

   rkx_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   rkx_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (head_valid),
      .head_data       (head_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_line_open   (rsp_line_open)
   );

endmodule

>>> hw/rtl/rkx_checker.sv
// Port-level checker for the XOR hex grouper, bound to the top level.
module rkx_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_of_run,
   input logic       rsp_line_open
);

   // A stalled beat keeps its character and flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_last_of_run) && $stable(rsp_line_open))
      else $error("stalled rsp beat changed");

   // Every character is a hex digit, a space or a newline.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char >= rkx_pkg::CHAR_ZERO && rsp_out_char <= rkx_pkg::CHAR_NINE)
         || (rsp_out_char >= rkx_pkg::CHAR_UPPER_A && rsp_out_char <= rkx_pkg::CHAR_UPPER_F)
         || rsp_out_char == rkx_pkg::CHAR_SPACE || rsp_out_char == rkx_pkg::CHAR_NEWLINE)
      else $error("rsp character outside the output alphabet");

   // A newline closes the line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_char == rkx_pkg::CHAR_NEWLINE |-> !rsp_line_open)
      else $error("line still open after a newline");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind repeating_key_xor_hex_grouper_unit rkx_checker u_rkx_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_char    (rsp_out_char),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_line_open   (rsp_line_open)
);

>>> bench/rkx_cipher_text_checker.sv
// Checker that predicts the grouped hex cipher text and compares every result beat.
module rkx_cipher_text_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [rkx_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [rkx_pkg::KEY_WIDTH-1:0]     csr_write_data,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [7:0]                        req_plain_byte,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [7:0]                        rsp_out_char,
   input  logic                              rsp_last_of_run,
   input  logic                              rsp_line_open,
   output int                                char_errors,
   output int                                pending_chars
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
      logic       line_open;
   } char_beat_type;

   char_beat_type expected_chars[$];

   logic [rkx_pkg::KEY_WIDTH-1:0] key_reg;
   logic [rkx_pkg::LEN_WIDTH-1:0] key_len_reg;
   logic [rkx_pkg::CPG_WIDTH-1:0] group_size_reg;
   logic [rkx_pkg::GPL_WIDTH-1:0] line_groups_reg;

   logic [2:0] key_pos;
   logic [5:0] chars_in_group;
   logic [7:0] groups_in_line;

   function automatic logic [7:0] ascii_of_nibble(input logic [3:0] nibble);
      return HEX_DIGITS[8*(15-int'(nibble)) +: 8];
   endfunction

   // A character that closes a group is followed by its separator; line_open
   // on the character itself reflects the group count before the separator.
   task automatic emit_char(input logic [7:0] ch);
      int next_chars;
      int next_groups;
      next_chars = int'(chars_in_group) + 1;
      if (next_chars >= int'(group_size_reg)) begin
         chars_in_group = '0;
         expected_chars.push_back('{ch, 1'b0, groups_in_line != 0});
         next_groups = int'(groups_in_line) + 1;
         if (next_groups >= int'(line_groups_reg)) begin
            groups_in_line = '0;
            expected_chars.push_back('{rkx_pkg::CHAR_NEWLINE, 1'b0, 1'b0});
         end else begin
            groups_in_line = next_groups[7:0];
            expected_chars.push_back('{rkx_pkg::CHAR_SPACE, 1'b0, 1'b1});
         end
      end else begin
         chars_in_group = next_chars[5:0];
         expected_chars.push_back('{ch, 1'b0, groups_in_line != 0});
      end
   endtask

   task automatic encrypt_byte(input logic [7:0] plain);
      int eff_len;
      int key_idx;
      logic [7:0] cipher;
      char_beat_type tail;
      eff_len = (key_len_reg == 0) ? 1 : ((key_len_reg > 8) ? 8 : int'(key_len_reg));
      key_idx = int'(key_pos);
      if (key_idx >= eff_len) begin
         key_idx = 0;
      end
      cipher = plain ^ key_reg[8*key_idx +: 8];
      key_idx = key_idx + 1;
      if (key_idx >= eff_len) begin
         key_idx = 0;
      end
      key_pos = key_idx[2:0];
      emit_char(ascii_of_nibble(cipher[7:4]));
      emit_char(ascii_of_nibble(cipher[3:0]));
      tail = expected_chars.pop_back();
      tail.last_of_run = 1'b1;
      expected_chars.push_back(tail);
   endtask

   initial begin
      char_errors = 0;
      pending_chars = 0;
   end

   always @(posedge clock) begin
      char_beat_type want;
      if (reset) begin
         key_reg = '0;
         key_len_reg = rkx_pkg::KEY_LENGTH_RESET;
         group_size_reg = rkx_pkg::CHARS_PER_GROUP_RESET;
         line_groups_reg = rkx_pkg::GROUPS_PER_LINE_RESET;
         key_pos = '0;
         chars_in_group = '0;
         groups_in_line = '0;
         expected_chars.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rkx_pkg::CSR_KEY_BYTES: key_reg = csr_write_data;
               rkx_pkg::CSR_KEY_LENGTH:
                  key_len_reg = csr_write_data[rkx_pkg::LEN_WIDTH-1:0];
               rkx_pkg::CSR_CHARS_PER_GROUP:
                  group_size_reg = csr_write_data[rkx_pkg::CPG_WIDTH-1:0];
               rkx_pkg::CSR_GROUPS_PER_LINE:
                  line_groups_reg = csr_write_data[rkx_pkg::GPL_WIDTH-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("out_char: no beat expected, got %h", rsp_out_char);
               char_errors++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.out_char) begin
                  $error("out_char: expected %h, got %h", want.out_char, rsp_out_char);
                  char_errors++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, got %b", want.last_of_run,
                         rsp_last_of_run);
                  char_errors++;
               end
               if (rsp_line_open !== want.line_open) begin
                  $error("line_open: expected %b, got %b", want.line_open, rsp_line_open);
                  char_errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            encrypt_byte(req_plain_byte);
         end
      end
      pending_chars = expected_chars.size();
   end

endmodule

>>> bench/repeating_key_xor_hex_grouper_unit_tb.sv
// Top of the bench: clock, reset, register settings and byte stimulus for the grouper.
module repeating_key_xor_hex_grouper_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [rkx_pkg::CSR_IDX_WIDTH-1:0] csr_index;
   logic [rkx_pkg::KEY_WIDTH-1:0]     csr_write_data;
   logic                              req_valid;
   logic                              req_stall;
   logic [7:0]                        req_plain_byte;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [7:0]                        rsp_out_char;
   logic                              rsp_last_of_run;
   logic                              rsp_line_open;

   int char_errors;
   int pending_chars;

   bit sender_idles;
   bit receiver_idles;
   bit stall_burst_req;

   logic [rkx_pkg::KEY_WIDTH-1:0] phase_key;

   repeating_key_xor_hex_grouper_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_plain_byte   (req_plain_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_line_open    (rsp_line_open)
   );

   rkx_cipher_text_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_plain_byte   (req_plain_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_line_open    (rsp_line_open),
      .char_errors      (char_errors),
      .pending_chars    (pending_chars)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("repeating_key_xor_hex_grouper_unit_tb: done, errors");
      $finish;
   end

   // Leaves the beat offered after the accepting edge; the next call either
   // replaces the payload or drops valid for an idle stretch.
   task automatic send_byte(input logic [7:0] plain);
      @(negedge clock);
      while (sender_idles && $urandom_range(0, 99) < 28) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_plain_byte = plain;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic write_reg(input logic [rkx_pkg::CSR_IDX_WIDTH-1:0] index,
                            input logic [rkx_pkg::KEY_WIDTH-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      @(negedge clock);
   endtask

   // Registers change only once every character in flight has drained.
   task automatic configure(input logic [rkx_pkg::KEY_WIDTH-1:0] key,
                            input logic [3:0] key_len,
                            input logic [5:0] group_size, input logic [7:0] line_groups);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_chars != 0) begin
         @(negedge clock);
      end
      write_reg(rkx_pkg::CSR_KEY_BYTES, key);
      write_reg(rkx_pkg::CSR_KEY_LENGTH, rkx_pkg::KEY_WIDTH'(key_len));
      write_reg(rkx_pkg::CSR_CHARS_PER_GROUP, rkx_pkg::KEY_WIDTH'(group_size));
      write_reg(rkx_pkg::CSR_GROUPS_PER_LINE, rkx_pkg::KEY_WIDTH'(line_groups));
      csr_write_enable = 1'b0;
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_burst_req) begin
            rsp_stall = 1'b1;
            repeat (80) @(negedge clock);
            stall_burst_req = 1'b0;
         end else begin
            rsp_stall = receiver_idles && ($urandom_range(0, 99) < 28);
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = rkx_pkg::CSR_KEY_BYTES;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_plain_byte = '0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      stall_burst_req = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Register defaults straight out of reset.
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h5a);
      send_byte(8'ha5);

      // Widest groups and lines; the key position moves to seven.
      phase_key = {$urandom, $urandom};
      configure(phase_key, 4'd8, 6'd63, 8'd255);
      send_byte(8'h0f);
      send_byte(8'hf0);
      send_byte(8'h3c);

      // Shorter key than the current position, and limits at or below the running counts.
      configure(phase_key, 4'd2, 6'd2, 8'd1);
      send_byte(8'hc3);
      send_byte(8'h81);
      send_byte(8'h7e);

      // Zero key length, group size and line length.
      configure(~phase_key, 4'd0, 6'd0, 8'd0);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h96);

      // Key length above eight.
      configure(phase_key, 4'd15, 6'd1, 8'd2);
      send_byte(8'h12);
      send_byte(8'hed);
      send_byte(8'h69);

      for (int phase = 0; phase < 8; phase++) begin
         phase_key = {$urandom, $urandom};
         case (phase)
            0: configure(phase_key, 4'd8, 6'd63, 8'd255);
            1: configure(phase_key, 4'd1, 6'd1, 8'd1);
            default: configure(phase_key, 4'($urandom_range(0, 15)),
                               $urandom_range(0, 1) ? 6'($urandom_range(0, 8))
                                                    : 6'($urandom_range(0, 63)),
                               $urandom_range(0, 1) ? 8'($urandom_range(0, 6))
                                                    : 8'($urandom_range(0, 255)));
         endcase
         sender_idles = (phase != 3);
         receiver_idles = (phase != 3);
         // Hold the output long enough that the queue fills and input stalls.
         if (phase == 2) begin
            stall_burst_req = 1'b1;
         end
         repeat (62) send_byte(8'($urandom_range(0, 255)));
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_chars != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      if (char_errors == 0) begin
         $display("repeating_key_xor_hex_grouper_unit_tb: done, clean");
      end else begin
         $display("repeating_key_xor_hex_grouper_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/rkx_pkg.sv
hw/rtl/rkx_queue.sv
hw/rtl/rkx_front.sv
hw/rtl/rkx_back.sv
hw/rtl/repeating_key_xor_hex_grouper_unit.sv
hw/rtl/rkx_checker.sv
bench/rkx_cipher_text_checker.sv
bench/repeating_key_xor_hex_grouper_unit_tb.sv
